FILE: rtl/snu_pkg.sv
// Package for the surface normal unit.
// Holds the lane count and the control word that travels beside each transaction.
// No dependencies.
package snu_pkg;

   // One lane for each component of the normal vector.
   localparam int LANES = 3;

   // Control word carried down the pipeline with each transaction.
   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LANES-1:0] neg;
   } snu_ctl_type;

endpackage

FILE: rtl/snu_if.sv
// Channel interfaces of the surface normal unit: vertex request and normal response.
// Both use a valid/ready handshake. No dependencies.
interface snu_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface snu_rsp_if #(parameter int NORMAL_FRAC_BITS = 14) ();
   logic                               valid;
   logic                               ready;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
   logic                               degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: rtl/snu_front.sv
// Front end of the surface normal unit: edge vectors, exact cross product,
// squared components and squared length. Depends on snu_pkg.
module snu_front #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14,
   parameter int LEN_W            = 4 * COORD_WIDTH + 4,
   parameter int TGT_W            = 4 * COORD_WIDTH + 2 + 2 * NORMAL_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [COORD_WIDTH-1:0]        a_x,
   input  logic signed [COORD_WIDTH-1:0]        a_y,
   input  logic signed [COORD_WIDTH-1:0]        a_z,
   input  logic signed [COORD_WIDTH-1:0]        b_x,
   input  logic signed [COORD_WIDTH-1:0]        b_y,
   input  logic signed [COORD_WIDTH-1:0]        b_z,
   input  logic signed [COORD_WIDTH-1:0]        c_x,
   input  logic signed [COORD_WIDTH-1:0]        c_y,
   input  logic signed [COORD_WIDTH-1:0]        c_z,
   output snu_pkg::snu_ctl_type                 ctl_out,
   output logic [LEN_W-1:0]                     len_out,
   output logic [snu_pkg::LANES-1:0][TGT_W-1:0] tgt_out
);
   import snu_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int EW = W + 1;
   localparam int PW = 2 * EW;
   localparam int MW = 2 * W + 1;
   localparam int LW = (MW + 1) / 2;
   localparam int HW = MW - LW;
   localparam int SW = 2 * MW;

   snu_ctl_type              ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;
   logic signed [EW-1:0]     e_ff [LANES];
   logic signed [EW-1:0]     f_ff [LANES];
   logic signed [EW-1:0]     e_in [LANES];
   logic signed [EW-1:0]     f_in [LANES];
   logic signed [PW-1:0]     prod_ff [2*LANES];
   logic signed [PW:0]       diff    [LANES];
   logic        [PW:0]       absd    [LANES];
   logic        [MW-1:0]     mag_ff  [LANES];
   logic        [LANES-1:0]  neg_in;
   logic        [2*HW-1:0]   hh_ff   [LANES];
   logic        [HW+LW-1:0]  hl_ff   [LANES];
   logic        [2*LW-1:0]   ll_ff   [LANES];
   logic        [SW-1:0]     sq_ff   [LANES];
   logic        [LEN_W-1:0]  len_in;
   logic        [LEN_W-1:0]  len_ff;
   logic [LANES-1:0][TGT_W-1:0] tgt_ff;

   // Edge vectors from the first vertex, one bit wider than the coordinates.
   always_comb begin
      e_in[0] = $signed({b_x[W-1], b_x}) - $signed({a_x[W-1], a_x});
      e_in[1] = $signed({b_y[W-1], b_y}) - $signed({a_y[W-1], a_y});
      e_in[2] = $signed({b_z[W-1], b_z}) - $signed({a_z[W-1], a_z});
      f_in[0] = $signed({c_x[W-1], c_x}) - $signed({a_x[W-1], a_x});
      f_in[1] = $signed({c_y[W-1], c_y}) - $signed({a_y[W-1], a_y});
      f_in[2] = $signed({c_z[W-1], c_z}) - $signed({a_z[W-1], a_z});
   end

   // Cross product differences, split into sign and magnitude.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff[i]   = $signed({prod_ff[2*i][PW-1], prod_ff[2*i]})
                   - $signed({prod_ff[2*i+1][PW-1], prod_ff[2*i+1]});
         neg_in[i] = diff[i][PW];
         absd[i]   = neg_in[i] ? (~diff[i] + 1'b1) : diff[i];
      end
      len_in = LEN_W'(sq_ff[0]) + LEN_W'(sq_ff[1]) + LEN_W'(sq_ff[2]);
   end

   // Control words: only the valid bit needs a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (en) begin
         ctl1_ff <= '{valid: in_valid, degen: 1'b0, neg: '0};
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= '{valid: ctl2_ff.valid, degen: ctl2_ff.degen, neg: neg_in};
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= '{valid: ctl5_ff.valid, degen: (len_in == '0), neg: ctl5_ff.neg};
      end
   end

   // Payload stages: edges, products, magnitudes, partial squares, squares, length and targets.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            e_ff[i] <= e_in[i];
            f_ff[i] <= f_in[i];
         end
         prod_ff[0] <= e_ff[1] * f_ff[2];
         prod_ff[1] <= e_ff[2] * f_ff[1];
         prod_ff[2] <= e_ff[2] * f_ff[0];
         prod_ff[3] <= e_ff[0] * f_ff[2];
         prod_ff[4] <= e_ff[0] * f_ff[1];
         prod_ff[5] <= e_ff[1] * f_ff[0];
         for (int i = 0; i < LANES; i++) begin
            mag_ff[i] <= absd[i][MW-1:0];
            hh_ff[i]  <= mag_ff[i][MW-1:LW] * mag_ff[i][MW-1:LW];
            hl_ff[i]  <= mag_ff[i][MW-1:LW] * mag_ff[i][LW-1:0];
            ll_ff[i]  <= mag_ff[i][LW-1:0] * mag_ff[i][LW-1:0];
            sq_ff[i]  <= (SW'(hh_ff[i]) << (2 * LW)) + (SW'(hl_ff[i]) << (LW + 1))
                       + SW'(ll_ff[i]);
            tgt_ff[i] <= TGT_W'(sq_ff[i]) << (2 * NORMAL_FRAC_BITS);
         end
         len_ff <= len_in;
      end
   end

   assign ctl_out = ctl6_ff;
   assign len_out = len_ff;
   assign tgt_out = tgt_ff;

endmodule

FILE: rtl/snu_cell.sv
// One cell of the quotient chain: decides one result bit for all three lanes
// by comparing q^2 * len2 against the target, kept incrementally. Depends on snu_pkg.
module snu_cell #(
   parameter int NORMAL_FRAC_BITS = 14,
   parameter int LEN_W            = 68,
   parameter int BIT              = 0
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   en,
   input  snu_pkg::snu_ctl_type                                   ctl_in,
   input  logic [LEN_W-1:0]                                       len_in,
   input  logic [snu_pkg::LANES-1:0][LEN_W+2*NORMAL_FRAC_BITS-3:0] tgt_in,
   input  logic [snu_pkg::LANES-1:0][NORMAL_FRAC_BITS:0]          q_in,
   input  logic [snu_pkg::LANES-1:0][LEN_W+NORMAL_FRAC_BITS:0]    ql_in,
   input  logic [snu_pkg::LANES-1:0][LEN_W+2*NORMAL_FRAC_BITS-3:0] q2l_in,
   output snu_pkg::snu_ctl_type                                   ctl_out,
   output logic [LEN_W-1:0]                                       len_out,
   output logic [snu_pkg::LANES-1:0][LEN_W+2*NORMAL_FRAC_BITS-3:0] tgt_out,
   output logic [snu_pkg::LANES-1:0][NORMAL_FRAC_BITS:0]          q_out,
   output logic [snu_pkg::LANES-1:0][LEN_W+NORMAL_FRAC_BITS:0]    ql_out,
   output logic [snu_pkg::LANES-1:0][LEN_W+2*NORMAL_FRAC_BITS-3:0] q2l_out
);
   import snu_pkg::*;

   localparam int F   = NORMAL_FRAC_BITS;
   localparam int TW  = LEN_W - 2 + 2 * F;
   localparam int QW  = F + 1;
   localparam int QLW = LEN_W + F + 1;
   localparam int CW  = TW + 4;

   snu_ctl_type               ctl_ff;
   logic [LEN_W-1:0]          len_ff;
   logic [LANES-1:0][TW-1:0]  tgt_ff, q2l_ff, q2l_nx;
   logic [LANES-1:0][QW-1:0]  q_ff, q_nx;
   logic [LANES-1:0][QLW-1:0] ql_ff, ql_nx;
   logic [CW-1:0]             cand [LANES];
   logic [LANES-1:0]          take;

   // Trial bit: (q + 2^b)^2 * L = q^2*L + q*L*2^(b+1) + L*2^(2b).
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         cand[i] = CW'(q2l_in[i]) + (CW'(ql_in[i]) << (BIT + 1))
                 + (CW'(len_in) << (2 * BIT));
         take[i] = (cand[i] <= CW'(tgt_in[i]));
         q_nx[i]   = take[i] ? (q_in[i] | (QW'(1) << BIT)) : q_in[i];
         q2l_nx[i] = take[i] ? cand[i][TW-1:0] : q2l_in[i];
         ql_nx[i]  = take[i] ? (ql_in[i] + (QLW'(len_in) << BIT)) : ql_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= len_in;
         tgt_ff <= tgt_in;
         q_ff   <= q_nx;
         ql_ff  <= ql_nx;
         q2l_ff <= q2l_nx;
      end
   end

   assign ctl_out = ctl_ff;
   assign len_out = len_ff;
   assign tgt_out = tgt_ff;
   assign q_out   = q_ff;
   assign ql_out  = ql_ff;
   assign q2l_out = q2l_ff;

endmodule

FILE: rtl/surface_normal_unit_core.sv
// Surface normal unit. Takes one triangle per cycle while not stalled (three Q8.8
// vertices) and returns the unit normal of (B-A) x (C-A) in signed Q1.14, each component
// truncated toward zero, with degenerate set and a zero vector when the cross product is
// zero. The pipeline is fully streaming: one transaction is accepted every cycle unless
// the output stalls. A result passes through edge, cross product and squared-length
// arithmetic, one cell per result bit in the quotient chain, and the output register.
// The whole pipeline holds only while a result waits at the output and the response
// side is not ready.
// Depends on snu_pkg, snu_if, snu_front and snu_cell.
module surface_normal_unit_core #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic        clock,
   input logic        reset,
   snu_req_if.sink    req,
   snu_rsp_if.source  rsp
);
   import snu_pkg::*;

   localparam int F     = NORMAL_FRAC_BITS;
   localparam int LEN_W = 4 * COORD_WIDTH + 4;
   localparam int TW    = LEN_W - 2 + 2 * F;
   localparam int QW    = F + 1;
   localparam int QLW   = LEN_W + F + 1;
   localparam int OW    = F + 2;
   localparam int NCELL = F + 1;

   logic                      en;
   snu_ctl_type               ctl_s [NCELL+1];
   logic [LEN_W-1:0]          len_s [NCELL+1];
   logic [LANES-1:0][TW-1:0]  tgt_s [NCELL+1];
   logic [LANES-1:0][QW-1:0]  q_s   [NCELL+1];
   logic [LANES-1:0][QLW-1:0] ql_s  [NCELL+1];
   logic [LANES-1:0][TW-1:0]  q2l_s [NCELL+1];
   logic                      rsp_valid_ff;
   logic                      degen_ff;
   logic signed [OW-1:0]      normal_ff [LANES];
   logic signed [OW-1:0]      normal_in [LANES];

   // The pipeline moves whenever the output register is empty or being drained.
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   snu_front #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (F),
      .LEN_W            (LEN_W),
      .TGT_W            (TW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .a_x      (req.a_x),
      .a_y      (req.a_y),
      .a_z      (req.a_z),
      .b_x      (req.b_x),
      .b_y      (req.b_y),
      .b_z      (req.b_z),
      .c_x      (req.c_x),
      .c_y      (req.c_y),
      .c_z      (req.c_z),
      .ctl_out  (ctl_s[0]),
      .len_out  (len_s[0]),
      .tgt_out  (tgt_s[0])
   );

   // The search starts from q = 0 in every lane.
   assign q_s[0]   = '0;
   assign ql_s[0]  = '0;
   assign q2l_s[0] = '0;

   // Chain of cells, most significant result bit first.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      snu_cell #(
         .NORMAL_FRAC_BITS (F),
         .LEN_W            (LEN_W),
         .BIT              (F - k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_s[k]),
         .len_in  (len_s[k]),
         .tgt_in  (tgt_s[k]),
         .q_in    (q_s[k]),
         .ql_in   (ql_s[k]),
         .q2l_in  (q2l_s[k]),
         .ctl_out (ctl_s[k+1]),
         .len_out (len_s[k+1]),
         .tgt_out (tgt_s[k+1]),
         .q_out   (q_s[k+1]),
         .ql_out  (ql_s[k+1]),
         .q2l_out (q2l_s[k+1])
      );
   end

   // Apply the sign, or force zero for a degenerate triangle.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (ctl_s[NCELL].degen) begin
            normal_in[i] = '0;
         end else if (ctl_s[NCELL].neg[i]) begin
            normal_in[i] = -$signed(OW'(q_s[NCELL][i]));
         end else begin
            normal_in[i] = $signed(OW'(q_s[NCELL][i]));
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_s[NCELL].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= ctl_s[NCELL].degen;
         for (int i = 0; i < LANES; i++) begin
            normal_ff[i] <= normal_in[i];
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.degenerate = degen_ff;
   assign rsp.normal_x   = normal_ff[0];
   assign rsp.normal_y   = normal_ff[1];
   assign rsp.normal_z   = normal_ff[2];

   localparam logic signed [OW-1:0] ONE  = OW'(1) <<< F;
   localparam logic signed [OW-1:0] MONE = -(OW'(1) <<< F);

   // A degenerate result carries a zero vector.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |->
         rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
      else $error("degenerate result with nonzero normal");

   // A proper triangle never yields an all-zero unit vector.
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.degenerate |->
         rsp.normal_x != '0 || rsp.normal_y != '0 || rsp.normal_z != '0)
      else $error("non-degenerate result with zero normal");

   // Every component stays within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |->
         rsp.normal_x <= ONE && rsp.normal_x >= MONE &&
         rsp.normal_y <= ONE && rsp.normal_y >= MONE &&
         rsp.normal_z <= ONE && rsp.normal_z >= MONE)
      else $error("normal component out of range");

   // A stalled output holds back the pipeline, so no request is taken.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request accepted while output stalled");

endmodule

FILE: tb/tb_top.sv
// Testbench for surface_normal_unit_core: drives vertex triangles, predicts the unit normal
// with an exact integer search, and compares every response field by field.
// Depends on snu_pkg, snu_if and the RTL of the surface normal unit.
`timescale 1ns / 100ps

module tb_top;

   localparam int CW = 16;
   localparam int FB = 14;
   localparam int OW = FB + 2;
   localparam int LATENCY = FB + 8;

   typedef struct {
      logic signed [CW-1:0] c[9];
   } tri_type;

   typedef struct {
      logic signed [OW-1:0] n[3];
      logic                 degen;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   normal_type normals_pending[$];

   snu_req_if #(.COORD_WIDTH(CW)) req ();
   snu_rsp_if #(.NORMAL_FRAC_BITS(FB)) rsp ();

   surface_normal_unit_core #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #4 clock = ~clock;

   // Exact unit normal: cross product in 41 bits, squared length in 82 bits, then
   // the largest q with q^2 * len2 <= x^2 * 2^(2*FB), found bit by bit.
   function automatic normal_type predict_normal(tri_type t);
      logic signed [17:0]  e[3], f[3];
      logic signed [40:0]  x[3];
      logic [39:0]         m[3];
      logic [81:0]         len2;
      logic [140:0]        target, lhs;
      logic [FB:0]         q, trial;
      normal_type          r;
      for (int i = 0; i < 3; i++) begin
         e[i] = 18'(t.c[3+i]) - 18'(t.c[i]);
         f[i] = 18'(t.c[6+i]) - 18'(t.c[i]);
      end
      x[0] = 41'(e[1]) * 41'(f[2]) - 41'(e[2]) * 41'(f[1]);
      x[1] = 41'(e[2]) * 41'(f[0]) - 41'(e[0]) * 41'(f[2]);
      x[2] = 41'(e[0]) * 41'(f[1]) - 41'(e[1]) * 41'(f[0]);
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = x[i] < 0 ? 40'(-x[i]) : 40'(x[i]);
         len2 += 82'(m[i]) * 82'(m[i]);
      end
      r.degen = (len2 == 0);
      for (int i = 0; i < 3; i++) begin
         q = '0;
         if (!r.degen) begin
            target = (141'(m[i]) * 141'(m[i])) << (2 * FB);
            for (int b = FB; b >= 0; b--) begin
               trial = q | ((FB+1)'(1) << b);
               lhs = 141'(trial) * 141'(trial) * 141'(len2);
               if (lhs <= target) q = trial;
            end
         end
         r.n[i] = x[i] < 0 ? -OW'(q) : OW'(q);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Send one transaction, idling at random beforehand.
   task automatic send_triangle(tri_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.a_x <= t.c[0]; req.a_y <= t.c[1]; req.a_z <= t.c[2];
      req.b_x <= t.c[3]; req.b_y <= t.c[4]; req.b_z <= t.c[5];
      req.c_x <= t.c[6]; req.c_y <= t.c[7]; req.c_z <= t.c[8];
      normals_pending.push_back(predict_normal(t));
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // Receiver stall pattern.
   always @(negedge clock)
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (normals_pending.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            want = normals_pending.pop_front();
            if (rsp.normal_x !== want.n[0]) report_mismatch("normal_x", rsp.normal_x, want.n[0]);
            if (rsp.normal_y !== want.n[1]) report_mismatch("normal_y", rsp.normal_y, want.n[1]);
            if (rsp.normal_z !== want.n[2]) report_mismatch("normal_z", rsp.normal_z, want.n[2]);
            if (rsp.degenerate !== want.degen)
               report_mismatch("degenerate", rsp.degenerate, want.degen);
         end
      end
   end

   function automatic tri_type make_triangle(int kind);
      tri_type t;
      int span;
      span = $urandom_range(3);
      for (int i = 0; i < 9; i++) begin
         case (span)
            0: t.c[i] = CW'($urandom());
            1: t.c[i] = CW'($urandom_range(16) - 8);
            2: t.c[i] = $urandom_range(1) ? 16'sh7fff - CW'($urandom_range(3))
                                          : 16'sh8000 + CW'($urandom_range(3));
            default: t.c[i] = CW'($urandom_range(2048) - 1024);
         endcase
      end
      // Occasionally collinear or coincident vertices.
      if (kind == 1) begin
         for (int i = 0; i < 3; i++) t.c[6+i] = t.c[3+i];
      end else if (kind == 2) begin
         for (int i = 0; i < 3; i++) t.c[6+i] = CW'(2 * t.c[3+i] - t.c[i]);
      end
      return t;
   endfunction

   function automatic tri_type tri_of(int v[9]);
      tri_type t;
      for (int i = 0; i < 9; i++) t.c[i] = CW'(v[i]);
      return t;
   endfunction

   // Drop valid and hold off until every expected response has come back.
   task automatic wait_drained();
      req.valid <= 1'b0;
      do @(negedge clock); while (normals_pending.size() != 0);
   endtask

   // Directed extremes, axis-aligned normals and degenerate triangles.
   task automatic test_directed();
      send_triangle(tri_of('{0, 0, 0, 256, 0, 0, 0, 256, 0}));
      send_triangle(tri_of('{0, 0, 0, 0, 256, 0, 256, 0, 0}));
      send_triangle(tri_of('{0, 0, 0, 0, 256, 0, 0, 0, 256}));
      send_triangle(tri_of('{0, 0, 0, 0, 0, 256, 256, 0, 0}));
      send_triangle(tri_of('{5, 5, 5, 5, 5, 5, 5, 5, 5}));
      send_triangle(tri_of('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
      send_triangle(tri_of('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      send_triangle(tri_of('{-32768, -32768, -32768, 32767, -32768, -32768,
                             -32768, 32767, -32768}));
      send_triangle(tri_of('{32767, 32767, 32767, -32768, 32767, 32767,
                             32767, -32768, -32768}));
      send_triangle(tri_of('{-32768, 32767, -32768, 32767, -32768, 32767,
                             -32768, -32768, 32767}));
      send_triangle(tri_of('{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767}));
      send_triangle(tri_of('{-1, -1, -1, 0, -1, -1, -1, 0, -1}));
      send_triangle(tri_of('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
      send_triangle(tri_of('{0, 0, 0, 3, 7, 1, -5, 2, 9}));
      send_triangle(tri_of('{-32768, -32768, -32768, -32768, -32768, -32768,
                             32767, 32767, 32767}));
      send_triangle(tri_of('{100, 200, 300, 300, 100, 200, 200, 300, 100}));
      wait_drained();
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int k = 0; k < count; k++) begin
         send_triangle(make_triangle($urandom_range(19) < 2 ? 1 + $urandom_range(1) : 0));
         // Hold off once until the pipeline has fully drained.
         if (k == count / 2 && s_pct == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.a_x = '0; req.a_y = '0; req.a_z = '0;
      req.b_x = '0; req.b_y = '0; req.b_z = '0;
      req.c_x = '0; req.c_y = '0; req.c_z = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(500, 31, 86);
      test_random(500, 86, 31);
      test_random(500, 0, 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && normals_pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
